[hdl/swd_pkg.sv]
// Shared types and constants for the sections work dispatcher.
`default_nettype none

package swd_pkg;

	// Default sizes of the slot ring and the per-thread tables.
	localparam int ALIVE_SLOTS_DEF = 4;
	localparam int MAX_THREADS_DEF = 64;

	// Field widths.
	localparam int TID_W  = 6;
	localparam int SEC_W  = 16;
	localparam int CNT_W  = 17;
	localparam int TEAM_W = 7;

	// Saturation value of the slot counters and solo positions.
	localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

	// Request type codes.
	localparam logic REQ_BEGIN = 1'b0;
	localparam logic REQ_NEXT  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} swd_cmd_t;

endpackage

`default_nettype wire

[hdl/swd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module swd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/swd_ctrl.sv]
// Controller state machine of the sections work dispatcher.
`default_nettype none

module swd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output swd_pkg::swd_cmd_t     cmd
);
	import swd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// A new transaction is taken only when no request is in progress.
	assign in_stall    = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	// The request completes once the output register is free or being emptied.
	assign cmd.commit  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/swd_dp.sv]
// Datapath of the sections work dispatcher: slot ring, thread table and result.
`default_nettype none

module swd_dp #(
	parameter int ALIVE_SLOTS = swd_pkg::ALIVE_SLOTS_DEF,
	parameter int MAX_THREADS = swd_pkg::MAX_THREADS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire swd_pkg::swd_cmd_t            cmd,
	input  wire logic                         cfg_write,
	input  wire logic [swd_pkg::TEAM_W-1:0]   cfg_data,
	input  wire logic                         req_type,
	input  wire logic [swd_pkg::TID_W-1:0]    thread_id,
	input  wire logic [swd_pkg::SEC_W-1:0]    section_total,
	output logic      [swd_pkg::SEC_W-1:0]    section_number,
	output logic                              must_wait
);
	import swd_pkg::*;

	localparam int SLOT_W = $clog2(ALIVE_SLOTS);
	localparam int IDX_W  = $clog2(MAX_THREADS);
	localparam int ENT_W  = SLOT_W + SEC_W + CNT_W;
	localparam int TID_N  = 1 << TID_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ALIVE_SLOTS - 1);

	// Mapping of thread numbers onto table rows, worked out at elaboration.
	logic [IDX_W-1:0] tid_map [TID_N];
	for (genvar gi = 0; gi < TID_N; gi++) begin : g_tid_map
		assign tid_map[gi] = IDX_W'(gi % MAX_THREADS);
	end

	// Configuration and captured request.
	logic [TEAM_W-1:0] team_q;
	logic              req_type_q;
	logic [IDX_W-1:0]  tid_q;
	logic [SEC_W-1:0]  sec_total_q;

	// Shared slot ring and per-thread valid bits.
	logic [CNT_W-1:0]       slot_count_q [ALIVE_SLOTS];
	logic [ALIVE_SLOTS-1:0] slot_stopped_q;
	logic [MAX_THREADS-1:0] ent_valid_q;

	// Thread table memory.
	logic             ent_we;
	logic [ENT_W-1:0] ent_wdata;
	logic [ENT_W-1:0] ent_rdata;
	logic [IDX_W-1:0] rd_idx;

	// Decoded table entry and next values.
	logic [SLOT_W-1:0] ent_slot, new_slot, slot_next, slot_prev;
	logic [SEC_W-1:0]  ent_total, new_total, take_total;
	logic [CNT_W-1:0]  ent_solo, new_solo, solo_inc;
	logic [CNT_W-1:0]  old_cnt, old_inc;
	logic              stopped, solo_mode, below, last_out, do_take;
	logic [SEC_W-1:0]  sec_d;
	logic              wait_d;

	assign rd_idx = tid_map[thread_id];

	swd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_THREADS)
	) u_thread_ram (
		.clk   (clk),
		.we    (cmd.commit && ent_we),
		.waddr (tid_q),
		.wdata (ent_wdata),
		.re    (cmd.capture),
		.raddr (rd_idx),
		.rdata (ent_rdata)
	);

	assign ent_wdata = {new_slot, new_total, new_solo};

	// Request evaluation against the thread entry and its slot.
	always_comb begin
		if (ent_valid_q[tid_q]) begin
			ent_slot  = ent_rdata[ENT_W-1 -: SLOT_W];
			ent_total = ent_rdata[CNT_W +: SEC_W];
			ent_solo  = ent_rdata[CNT_W-1:0];
		end else begin
			ent_slot  = '0;
			ent_total = '0;
			ent_solo  = '0;
		end
		solo_mode  = (team_q <= TEAM_W'(1));
		old_cnt    = slot_count_q[ent_slot];
		stopped    = slot_stopped_q[ent_slot];
		slot_next  = (ent_slot == SLOT_LAST) ? '0 : ent_slot + SLOT_W'(1);
		slot_prev  = (ent_slot == '0) ? SLOT_LAST : ent_slot - SLOT_W'(1);
		take_total = (req_type_q == REQ_BEGIN) ? sec_total_q : ent_total;
		old_inc    = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + CNT_W'(1);
		solo_inc   = (ent_solo == CNT_MAX) ? CNT_MAX : ent_solo + CNT_W'(1);
		below      = (old_cnt < CNT_W'(take_total));
		last_out   = (old_cnt == CNT_W'(take_total) + CNT_W'(team_q) - CNT_W'(1));

		sec_d     = '0;
		wait_d    = 1'b0;
		ent_we    = 1'b0;
		do_take   = 1'b0;
		new_slot  = ent_slot;
		new_total = ent_total;
		new_solo  = ent_solo;

		if (req_type_q == REQ_BEGIN) begin
			if (sec_total_q == '0) begin
				sec_d = '0;
			end else if (solo_mode) begin
				ent_we    = 1'b1;
				new_total = sec_total_q;
				new_solo  = CNT_W'(1);
				sec_d     = SEC_W'(1);
			end else if (stopped) begin
				wait_d = 1'b1;
			end else begin
				ent_we    = 1'b1;
				new_total = sec_total_q;
				do_take   = 1'b1;
			end
		end else begin
			if (solo_mode) begin
				ent_we   = 1'b1;
				new_solo = solo_inc;
				if (solo_inc <= CNT_W'(ent_total)) begin
					sec_d = solo_inc[SEC_W-1:0];
				end
			end else if (!stopped) begin
				do_take = 1'b1;
			end
		end

		// Shared slot: hand out the next section or leave the construct.
		if (do_take) begin
			if (below) begin
				sec_d = old_cnt[SEC_W-1:0] + SEC_W'(1);
			end else begin
				ent_we   = 1'b1;
				new_slot = slot_next;
			end
		end
	end

	// Configuration, slot ring and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			team_q         <= TEAM_W'(1);
			slot_stopped_q <= ALIVE_SLOTS'(1) << (ALIVE_SLOTS - 1);
			ent_valid_q    <= '0;
			for (int i = 0; i < ALIVE_SLOTS; i++) begin
				slot_count_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				team_q <= cfg_data;
			end
			if (cmd.commit && ent_we) begin
				ent_valid_q[tid_q] <= 1'b1;
			end
			if (cmd.commit && do_take) begin
				if (below || !last_out) begin
					slot_count_q[ent_slot] <= old_inc;
				end else begin
					slot_count_q[ent_slot]   <= '0;
					slot_stopped_q[ent_slot] <= 1'b1;
					slot_count_q[slot_prev]  <= '0;
					slot_stopped_q[slot_prev] <= 1'b0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q  <= req_type;
			tid_q       <= rd_idx;
			sec_total_q <= section_total;
		end
		if (cmd.commit) begin
			section_number <= sec_d;
			must_wait      <= wait_d;
		end
	end

endmodule

`default_nettype wire

[hdl/sections_work_dispatcher.sv]
// Top level of the sections work dispatcher.
//
// Threads of a team send requests on the input channel (in_valid / in_stall):
// req_type selects begin (carries section_total) or next, thread_id names the
// thread. Each request produces exactly one result transaction on the output
// channel (out_valid / out_stall): the 1-based section_number to run, 0 to
// leave the construct, and must_wait when a begin hits a slot that is still
// stopped. team_size is written through cfg_write / cfg_data; the user must
// do so only while idle, which the block itself does not enforce. Each
// request first reads the thread's entry from the thread table RAM, then
// evaluates and writes back the entry and the slot counter; a new transaction
// is accepted only after that write-back, which also fills the output register.
// The output register keeps a result while out_stall is high; the block can
// take the next request meanwhile but holds its evaluation until the output
// register is free. Reset clears the slot counters, stops only the last slot,
// marks every thread entry as zero and sets team_size to 1; no clearing pass
// is needed.
`default_nettype none

module sections_work_dispatcher #(
	parameter int ALIVE_SLOTS = swd_pkg::ALIVE_SLOTS_DEF,
	parameter int MAX_THREADS = swd_pkg::MAX_THREADS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [swd_pkg::TEAM_W-1:0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic [swd_pkg::TID_W-1:0]    thread_id,
	input  wire logic [swd_pkg::SEC_W-1:0]    section_total,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [swd_pkg::SEC_W-1:0]    section_number,
	output logic                              must_wait
);
	import swd_pkg::*;

	swd_cmd_t cmd;

	// Sequencing of each request.
	swd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Slot ring, thread table and result registers.
	swd_dp #(
		.ALIVE_SLOTS (ALIVE_SLOTS),
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.thread_id      (thread_id),
		.section_total  (section_total),
		.section_number (section_number),
		.must_wait      (must_wait)
	);

endmodule

`default_nettype wire

[tb/sections_work_dispatcher_tb.sv]
// Self-checking testbench for the sections work dispatcher, with a built-in predictor.
`default_nettype none

module sections_work_dispatcher_tb;
	import swd_pkg::*;

	localparam int SLOTS       = ALIVE_SLOTS_DEF;
	localparam int THREADS     = MAX_THREADS_DEF;
	localparam int RING_W      = $clog2(SLOTS);
	localparam int CYCLE_LIMIT = 200_000;
	localparam int SOLO_NEXTS  = 30;
	localparam int SOLO_TOTAL  = 24;
	localparam int TAIL_CYCLES = 16;

	// One request as the sender puts it on the wire.
	typedef struct packed {
		logic              kind;
		logic [TID_W-1:0]  tid;
		logic [SEC_W-1:0]  total;
	} disp_req_t;

	// One grant as the block should answer it.
	typedef struct packed {
		logic [SEC_W-1:0]  section;
		logic              must_wait;
	} disp_grant_t;

	// Shared slot ring, per-thread tables and the team size.
	typedef struct packed {
		logic [TEAM_W-1:0]                 team;
		logic [SLOTS-1:0][CNT_W-1:0]       slot_count;
		logic [SLOTS-1:0]                  slot_stopped;
		logic [THREADS-1:0][RING_W-1:0]    thread_slot;
		logic [THREADS-1:0][SEC_W-1:0]     thread_total;
		logic [THREADS-1:0][CNT_W-1:0]     solo_pos;
	} disp_state_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [TEAM_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = REQ_BEGIN;
	logic [TID_W-1:0]  thread_id = '0;
	logic [SEC_W-1:0]  section_total = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SEC_W-1:0]  section_number;
	logic              must_wait;

	disp_state_t live_disp;
	disp_state_t plan_disp;
	disp_req_t   req_backlog[$];
	disp_grant_t grant_fifo[$];
	disp_req_t   on_wire;
	bit          bubbles_on = 1'b1;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          mismatches = 0;
	int          cycles = 0;

	sections_work_dispatcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.thread_id     (thread_id),
		.section_total (section_total),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.section_number(section_number),
		.must_wait     (must_wait)
	);

	// Clock with a period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// State right after reset: only the last slot is stopped.
	function automatic disp_state_t fresh_disp();
		disp_state_t st;
		st = '0;
		st.team = TEAM_W'(1);
		st.slot_stopped[SLOTS-1] = 1'b1;
		return st;
	endfunction

	// Works out the grant for one request and updates the dispatcher state.
	task automatic hand_out(inout disp_state_t st, input disp_req_t rq,
			output disp_grant_t g);
		int tid;
		int idx;
		int prev;
		logic [CNT_W-1:0] crew;
		logic [CNT_W-1:0] old;
		logic [CNT_W-1:0] cap;
		logic take;
		tid = int'(rq.tid) % THREADS;
		idx = int'(st.thread_slot[tid]) % SLOTS;
		crew = (st.team == '0) ? CNT_W'(1) : CNT_W'(st.team);
		g = '0;
		take = 1'b0;

		if (rq.kind == REQ_BEGIN) begin
			if (rq.total == '0) begin
				// An empty construct leaves every table untouched.
				g.section = '0;
			end else if (crew == CNT_W'(1)) begin
				st.thread_total[tid] = rq.total;
				st.solo_pos[tid] = CNT_W'(1);
				g.section = SEC_W'(1);
			end else if (st.slot_stopped[idx]) begin
				g.must_wait = 1'b1;
			end else begin
				st.thread_total[tid] = rq.total;
				take = 1'b1;
			end
		end else begin
			if (crew == CNT_W'(1)) begin
				if (st.solo_pos[tid] != CNT_MAX)
					st.solo_pos[tid] = st.solo_pos[tid] + 1'b1;
				if (st.solo_pos[tid] <= CNT_W'(st.thread_total[tid]))
					g.section = st.solo_pos[tid][SEC_W-1:0];
			end else if (!st.slot_stopped[idx]) begin
				take = 1'b1;
			end
		end

		// Shared slot: count the request, hand out a section or leave.
		if (take) begin
			old = st.slot_count[idx];
			cap = CNT_W'(st.thread_total[tid]);
			if (old != CNT_MAX)
				st.slot_count[idx] = old + 1'b1;
			if (old < cap) begin
				g.section = SEC_W'(old + 1'b1);
			end else begin
				if (old == cap + crew - 1'b1) begin
					// Last thread out stops this slot and frees the one before it.
					prev = (idx + SLOTS - 1) % SLOTS;
					st.slot_stopped[idx] = 1'b1;
					st.slot_count[idx] = '0;
					st.slot_stopped[prev] = 1'b0;
					st.slot_count[prev] = '0;
				end
				st.thread_slot[tid] = RING_W'((idx + 1) % SLOTS);
			end
		end
	endtask

	// Prints one line for each mismatch and counts it.
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d",
			cycles, what, got, want);
		mismatches++;
	endtask

	// Queues one request and tells the planner what it will answer.
	task automatic issue(input logic kind, input int tid, input int total,
			output disp_grant_t g);
		disp_req_t rq;
		rq.kind = kind;
		rq.tid = TID_W'(tid);
		rq.total = SEC_W'(total);
		hand_out(plan_disp, rq, g);
		req_backlog.push_back(rq);
	endtask

	// Waits until every request has been sent and answered.
	task automatic drain();
		while (req_backlog.size() != 0 || grant_fifo.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// Writes team_size once the block has gone quiet.
	task automatic set_team(input int size);
		drain();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= TEAM_W'(size);
		@(posedge clk);
		cfg_write <= 1'b0;
		live_disp.team = TEAM_W'(size);
		plan_disp.team = TEAM_W'(size);
		@(negedge clk);
	endtask

	// Section count of a construct: mostly a handful, sometimes none or many.
	function automatic int pick_sections();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(7, 40);
		return $urandom_range(1, 6);
	endfunction

	// A crew of threads runs back-to-back constructs at random speeds; each
	// thread begins, asks for more until told to leave, then moves on.
	// A few stray requests are mixed in.
	task automatic plan_phase(input int budget, input int crew);
		int base;
		int left;
		int pick;
		int tid;
		int total;
		int r;
		bit member;
		int stage[THREADS];
		bit begun[THREADS];
		int sizes[$];
		disp_grant_t g;
		base = $urandom_range(0, THREADS - 1);
		for (int k = 0; k < THREADS; k++) begin
			stage[k] = 0;
			begun[k] = 1'b0;
		end
		left = budget;
		while (left > 0) begin
			if ($urandom_range(0, 11) == 0) begin
				tid = $urandom_range(0, THREADS - 1);
				member = ((tid - base + THREADS) % THREADS) < crew;
				r = $urandom_range(0, 7);
				if (member)
					total = $urandom_range(0, 6);
				else if (r == 0)
					total = 0;
				else if (r == 1)
					total = 16'hFFFF;
				else
					total = $urandom_range(0, 16'hFFFF);
				issue(logic'($urandom_range(0, 1)), tid, total, g);
			end else begin
				pick = $urandom_range(0, crew - 1);
				tid = (base + pick) % THREADS;
				while (sizes.size() <= stage[pick])
					sizes.push_back(pick_sections());
				if (begun[pick])
					issue(REQ_NEXT, tid, $urandom_range(0, 16'hFFFF), g);
				else
					issue(REQ_BEGIN, tid, sizes[stage[pick]], g);
				if (g.must_wait) begin
					begun[pick] = 1'b0;
				end else if (g.section == '0) begin
					stage[pick]++;
					begun[pick] = 1'b0;
				end else begin
					begun[pick] = 1'b1;
				end
			end
			left--;
		end
	endtask

	// Sender: takes requests from the backlog, with random pauses.
	always @(posedge clk) begin : driver
		disp_grant_t g;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				hand_out(live_disp, on_wire, g);
				grant_fifo.push_back(g);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					on_wire = req_backlog.pop_front();
					in_valid <= 1'b1;
					req_type <= on_wire.kind;
					thread_id <= on_wire.tid;
					section_total <= on_wire.total;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transaction and stalls in random bursts.
	always @(posedge clk) begin : monitor
		disp_grant_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grant_fifo.size() == 0) begin
					flag_mismatch("unrequested result, section_number",
						int'(section_number), 0);
				end else begin
					want = grant_fifo.pop_front();
					if (section_number !== want.section)
						flag_mismatch("section_number", int'(section_number),
							int'(want.section));
					if (must_wait !== want.must_wait)
						flag_mismatch("must_wait", int'(must_wait), int'(want.must_wait));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Test sequence: directed requests, then phases with various team sizes.
	initial begin : stimulus
		disp_grant_t g;
		int teams[7];
		int budgets[7];
		int crew;
		int sat_tid;
		teams = '{1, 0, 2, 3, 5, 64, 127};
		budgets = '{150, 60, 120, 200, 150, 200, 60};
		live_disp = fresh_disp();
		plan_disp = fresh_disp();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-thread team: empty construct, largest construct, running out.
		set_team(1);
		issue(REQ_BEGIN, 0, 0, g);
		issue(REQ_BEGIN, 63, 16'hFFFF, g);
		issue(REQ_NEXT, 63, 0, g);
		issue(REQ_BEGIN, 5, 2, g);
		issue(REQ_NEXT, 5, 16'hFFFF, g);
		issue(REQ_NEXT, 5, 0, g);
		issue(REQ_NEXT, 5, 0, g);
		issue(REQ_NEXT, 9, 0, g);

		// Two threads: finish a construct, then hit the stopped slot.
		set_team(2);
		issue(REQ_BEGIN, 0, 1, g);
		issue(REQ_NEXT, 0, 0, g);
		issue(REQ_BEGIN, 1, 1, g);
		issue(REQ_NEXT, 2, 0, g);
		issue(REQ_BEGIN, 2, 5, g);
		issue(REQ_BEGIN, 3, 16'hFFFF, g);
		issue(REQ_BEGIN, 4, 0, g);
		issue(REQ_BEGIN, 0, 2, g);
		issue(REQ_NEXT, 0, 0, g);
		issue(REQ_NEXT, 0, 0, g);
		issue(REQ_NEXT, 63, 0, g);

		// Random phases over the team sizes, zero and all ones among them.
		for (int p = 0; p < 7; p++) begin
			set_team(teams[p]);
			crew = (teams[p] <= 1) ? $urandom_range(1, 6) :
				((teams[p] > THREADS) ? THREADS : teams[p]);
			plan_phase(budgets[p], crew);
		end

		// Solo run at full rate that walks past the end of its construct.
		set_team(1);
		bubbles_on = 1'b0;
		sat_tid = $urandom_range(0, THREADS - 1);
		issue(REQ_BEGIN, sat_tid, SOLO_TOTAL, g);
		for (int n = 0; n < SOLO_NEXTS; n++)
			issue(REQ_NEXT, sat_tid, 0, g);

		// Closing phase at full rate.
		set_team($urandom_range(2, 16));
		plan_phase(150, $urandom_range(2, 8));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hdl/swd_pkg.sv
hdl/swd_ram.sv
hdl/swd_ctrl.sv
hdl/swd_dp.sv
hdl/sections_work_dispatcher.sv
tb/sections_work_dispatcher_tb.sv
